@@ design/clpc_pkg.sv @@
`timescale 1ns / 1ps

package clpc_pkg;

    localparam int ARG_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int ENABLE_WIDTH = 5;
    localparam int OUT_ARG_WIDTH = 32;
    localparam int TDATA_WIDTH = 96;
    localparam int TUSER_WIDTH = 4;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VTAB = 8'h0b;
    localparam logic [7:0] CH_FFEED = 8'h0c;
    localparam logic [7:0] CH_PLUS = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_H = 8'h68;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_M = 8'h6d;
    localparam logic [7:0] CH_A = 8'h61;

    localparam logic [2:0] CMD_HOME = 3'd0;
    localparam logic [2:0] CMD_TARE = 3'd1;
    localparam logic [2:0] CMD_FILL = 3'd2;
    localparam logic [2:0] CMD_MOVE = 3'd3;
    localparam logic [2:0] CMD_SERVO = 3'd4;
    localparam logic [2:0] CMD_UNKNOWN = 3'd5;

    typedef enum logic [2:0] {
        TK_LF    = 3'd0,
        TK_COLON = 3'd1,
        TK_SPACE = 3'd2,
        TK_SIGN  = 3'd3,
        TK_DIGIT = 3'd4,
        TK_OTHER = 3'd5
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] val;
        logic [2:0] code;
    } token_t;

    typedef enum logic [2:0] {
        CP_IDLE   = 3'b001,
        CP_LETTER = 3'b010,
        CP_FIELDS = 3'b100
    } char_pos_t;

    typedef enum logic [2:0] {
        PH_SKIP = 3'b001,
        PH_NUM  = 3'b010,
        PH_DONE = 3'b100
    } num_phase_t;

endpackage

@@ design/clpc_front.sv @@
`timescale 1ns / 1ps

module clpc_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              q_ready,
    output logic              push,
    output clpc_pkg::token_t  tok
);
    import clpc_pkg::*;

    function automatic logic [2:0] letter_code(input logic [7:0] c);
        logic [2:0] r;
        unique case (c)
            CH_H:    r = CMD_HOME;
            CH_T:    r = CMD_TARE;
            CH_F:    r = CMD_FILL;
            CH_M:    r = CMD_MOVE;
            CH_A:    r = CMD_SERVO;
            default: r = CMD_UNKNOWN;
        endcase
        return r;
    endfunction

    assign s_tready = q_ready;

    // drop carriage return at the door
    assign push = s_tvalid && q_ready && (s_tdata != CH_CR);

    always_comb
    begin
        tok.code = letter_code(s_tdata);
        tok.val  = 4'(s_tdata - CH_ZERO);
        if (s_tdata == CH_LF)
        begin
            tok.kind = TK_LF;
        end
        else if (s_tdata == CH_COLON)
        begin
            tok.kind = TK_COLON;
        end
        else if (s_tdata == CH_SPACE || s_tdata == CH_TAB ||
                 s_tdata == CH_VTAB || s_tdata == CH_FFEED)
        begin
            tok.kind = TK_SPACE;
        end
        else if (s_tdata == CH_PLUS || s_tdata == CH_MINUS)
        begin
            tok.kind = TK_SIGN;
            tok.val  = {3'b000, s_tdata == CH_MINUS};
        end
        else if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE)
        begin
            tok.kind = TK_DIGIT;
        end
        else
        begin
            tok.kind = TK_OTHER;
        end
    end

endmodule

@@ design/clpc_queue.sv @@
`timescale 1ns / 1ps

module clpc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  clpc_pkg::token_t  push_tok,
    output logic              not_full,
    input  logic              pop,
    output logic              not_empty,
    output clpc_pkg::token_t  head_tok
);
    import clpc_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    token_t              slot_reg [QUEUE_DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [CntW-1:0]     count_reg;
    logic [CntW-1:0]     count_next;

    assign not_full  = (count_reg != CntW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_tok  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ design/clpc_back.sv @@
`timescale 1ns / 1ps

module clpc_back #(
    parameter int ARG_WIDTH = clpc_pkg::ARG_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [clpc_pkg::ENABLE_WIDTH-1:0]     cfg_wr_data,
    input  logic                                  tok_valid,
    input  clpc_pkg::token_t                      tok,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [clpc_pkg::TDATA_WIDTH-1:0]      m_tdata,
    output logic [clpc_pkg::TUSER_WIDTH-1:0]      m_tuser
);
    import clpc_pkg::*;

    localparam int ProdW = ARG_WIDTH + 4;
    localparam logic [ProdW-1:0] LimNeg = ProdW'(1) << (ARG_WIDTH - 1);
    localparam logic [ProdW-1:0] LimPos = LimNeg - 1'b1;

    logic [ENABLE_WIDTH-1:0] enable_reg;

    char_pos_t      cp_reg, cp_next;
    num_phase_t     ph_reg, ph_next;
    logic [1:0]     fi_reg, fi_next;
    logic [2:0]     code_reg, code_next;
    logic [2:0]     present_reg, present_next;
    logic [2:0]     neg_reg, neg_next;
    logic [ARG_WIDTH-1:0] mag_reg [3];
    logic [ARG_WIDTH-1:0] mag_next [3];

    logic                 out_valid_reg, out_valid_next;
    logic [TDATA_WIDTH-1:0] out_data_reg, out_data_next;
    logic [TUSER_WIDTH-1:0] out_user_reg, out_user_next;

    logic [ARG_WIDTH-1:0] cur_mag;
    logic                 cur_neg;
    logic [ProdW-1:0]     prod;
    logic [ProdW-1:0]     limit;
    logic [ARG_WIDTH-1:0] new_mag;
    logic [OUT_ARG_WIDTH-1:0] arg_out [3];
    logic [7:0]           en_ext;
    logic                 emit;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign pop = tok_valid && (!out_valid_reg || m_tready);
    assign emit = pop && (tok.kind == TK_LF) && (cp_reg != CP_IDLE);

    always_comb
    begin
        unique case (fi_reg)
            2'd0:    begin cur_mag = mag_reg[0]; cur_neg = neg_reg[0]; end
            2'd1:    begin cur_mag = mag_reg[1]; cur_neg = neg_reg[1]; end
            default: begin cur_mag = mag_reg[2]; cur_neg = neg_reg[2]; end
        endcase
        prod  = ({4'b0000, cur_mag} << 3) + ({4'b0000, cur_mag} << 1)
              + {{ARG_WIDTH{1'b0}}, tok.val};
        limit = cur_neg ? LimNeg : LimPos;
        new_mag = (prod > limit) ? limit[ARG_WIDTH-1:0] : prod[ARG_WIDTH-1:0];
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_arg
        logic signed [ARG_WIDTH-1:0] sval;
        assign sval = neg_reg[k] ? -$signed(mag_reg[k]) : $signed(mag_reg[k]);
        assign arg_out[k] = present_reg[k] ? OUT_ARG_WIDTH'(sval) : '1;
    end

    assign en_ext = {{(8 - ENABLE_WIDTH){1'b0}}, enable_reg};

    always_comb
    begin
        cp_next      = cp_reg;
        ph_next      = ph_reg;
        fi_next      = fi_reg;
        code_next    = code_reg;
        present_next = present_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;

        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {arg_out[2], arg_out[1], arg_out[0]};
            out_user_next  = {(code_reg != CMD_UNKNOWN) && en_ext[code_reg], code_reg};
        end

        if (pop)
        begin
            if (tok.kind == TK_LF)
            begin
                cp_next      = CP_IDLE;
                ph_next      = PH_SKIP;
                fi_next      = 2'd0;
                present_next = 3'b000;
                neg_next     = 3'b000;
            end
            else
            begin
                unique case (cp_reg)
                    CP_IDLE:
                    begin
                        code_next = tok.code;
                        cp_next   = CP_LETTER;
                    end
                    CP_LETTER:
                    begin
                        cp_next         = CP_FIELDS;
                        fi_next         = 2'd0;
                        ph_next         = PH_SKIP;
                        present_next[0] = 1'b1;
                        neg_next[0]     = 1'b0;
                        mag_next[0]     = '0;
                    end
                    CP_FIELDS:
                    begin
                        if (fi_reg != 2'd3)
                        begin
                            if (tok.kind == TK_COLON)
                            begin
                                fi_next = fi_reg + 1'b1;
                                if (fi_reg != 2'd2)
                                begin
                                    ph_next                  = PH_SKIP;
                                    present_next[fi_next]    = 1'b1;
                                    neg_next[fi_next]        = 1'b0;
                                    mag_next[fi_next]        = '0;
                                end
                            end
                            else
                            begin
                                unique case (ph_reg)
                                    PH_SKIP:
                                    begin
                                        if (tok.kind == TK_SIGN)
                                        begin
                                            neg_next[fi_reg] = tok.val[0];
                                            ph_next          = PH_NUM;
                                        end
                                        else if (tok.kind == TK_DIGIT)
                                        begin
                                            mag_next[fi_reg] = new_mag;
                                            ph_next          = PH_NUM;
                                        end
                                        else if (tok.kind != TK_SPACE)
                                        begin
                                            ph_next = PH_DONE;
                                        end
                                    end
                                    PH_NUM:
                                    begin
                                        if (tok.kind == TK_DIGIT)
                                        begin
                                            mag_next[fi_reg] = new_mag;
                                        end
                                        else
                                        begin
                                            ph_next = PH_DONE;
                                        end
                                    end
                                    default:
                                    begin
                                        ph_next = ph_reg;
                                    end
                                endcase
                            end
                        end
                    end
                    default:
                    begin
                        cp_next = CP_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        code_reg     <= code_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= '0;
            cp_reg        <= CP_IDLE;
            ph_reg        <= PH_SKIP;
            fi_reg        <= 2'd0;
            present_reg   <= 3'b000;
            neg_reg       <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                enable_reg <= cfg_wr_data;
            end
            cp_reg        <= cp_next;
            ph_reg        <= ph_next;
            fi_reg        <= fi_next;
            present_reg   <= present_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/colon_command_line_parser_core.sv @@
`timescale 1ns / 1ps

// Colon command line parser.
// Slave stream: one received character per beat in s_tdata[7:0].
// Master stream: one beat per non-empty line, sent when the line feed is
// processed. m_tdata holds arg_first [31:0], arg_second [63:32],
// arg_third [95:64]; m_tuser holds command [2:0] and accepted [3].
// Configuration: cfg_wr_en writes cfg_wr_data into the five handler
// enable bits; write only while the block is idle.
// A front stage classifies each character into a four-entry token queue;
// the back stage runs the line state and the multiply-by-ten update.
// Throughput: one character per cycle while the receiver does not stall,
// with each digit accumulated as the back stage pops it. A line feed
// reaches its result beat through the token queue and the output register.
// Reset clears the queue, the line state, the enables and the output valid.
// When the receiver stalls, the result holds in the output register, the
// back stage halts and the queue fills; s_tready falls once it is full.
module colon_command_line_parser_core #(
    parameter int ARG_WIDTH = clpc_pkg::ARG_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [clpc_pkg::ENABLE_WIDTH-1:0]     cfg_wr_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,    // rx_byte
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [clpc_pkg::TDATA_WIDTH-1:0]      m_tdata,    // arg_first, arg_second, arg_third
    output logic [clpc_pkg::TUSER_WIDTH-1:0]      m_tuser     // command, accepted
);
    import clpc_pkg::*;

    token_t in_tok;
    token_t head_tok;
    logic   push;
    logic   pop;
    logic   q_not_full;
    logic   q_not_empty;

    clpc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_ready  (q_not_full),
        .push     (push),
        .tok      (in_tok)
    );

    clpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_tok  (in_tok),
        .not_full  (q_not_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_tok  (head_tok)
    );

    clpc_back #(
        .ARG_WIDTH (ARG_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tok_valid   (q_not_empty),
        .tok         (head_tok),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

@@ design/clpc_checker.sv @@
`timescale 1ns / 1ps

module clpc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata,
    input logic [3:0]   m_tuser
);

    localparam logic [2:0] CodeUnknown = 3'd5;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[2:0] <= CodeUnknown)
        else $error("command code out of range");

    a_unknown_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2:0] == CodeUnknown |-> !m_tuser[3])
        else $error("unknown command flagged as accepted");

endmodule

bind colon_command_line_parser_core clpc_checker u_clpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
